@@ rtl/core/dhte_pkg.sv @@
package dhte_pkg;

    // Table geometry
    localparam int SLOTS_DEF = 1031;

    // Field widths of the request and result
    localparam int OP_W    = 2;
    localparam int KEY_W   = 31;
    localparam int VAL_W   = 32;
    localparam int SLOT_W  = 11;
    localparam int COUNT_W = 11;

    // First-probe scramble
    localparam logic [KEY_W-1:0] KEY_XOR = 31'h400_0000;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_GET  = 2'd0;
    localparam logic [OP_W-1:0] OP_PUT  = 2'd1;
    localparam logic [OP_W-1:0] OP_REM  = 2'd2;
    localparam logic [OP_W-1:0] OP_SCAN = 2'd3;

    // Slot status codes
    localparam logic [1:0] ST_EMPTY   = 2'd0;
    localparam logic [1:0] ST_USED    = 2'd1;
    localparam logic [1:0] ST_DELETED = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic clr;       // write one empty slot of the clearing pass
        logic hash;      // one step of both remainders
        logic pinit;     // start probe sequence
        logic pchk;      // evaluate probed slot
        logic act;       // apply request to the located slot
        logic schk;      // evaluate scanned slot
        logic out_load;  // move result to the output register
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_done;
        logic in_scan;
        logic in_oob;
        logic hash_last;
        logic chk_done;
        logic schk_done;
        logic out_busy;
    } t_sts;

endpackage

@@ rtl/core/double_hash_table_engine.sv @@
// Key-value table with open addressing and double hashing over TABLE_SLOTS slots
// held in one single-port-write, registered-read memory. After reset the block
// runs a clearing pass over all TABLE_SLOTS slots with o_ready low. A get, put or
// remove is accepted, forms both hash remainders by reciprocal multiplication
// (quotient, difference, correction), starts the probe, reads and then checks each
// probed slot in turn, updates the slot and posts the result. A scan reads
// and checks slot after slot from its start slot until a used slot or the last
// slot; a start slot beyond the table goes straight to posting. One request is in
// flight at a time; the result register lets the next request enter while a result
// waits, and posting a result waits while the previous one is still stalled.
module double_hash_table_engine #(
    parameter int TABLE_SLOTS = dhte_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dhte_pkg::OP_W-1:0]    i_opcode,
    input  logic [dhte_pkg::KEY_W-1:0]   i_key,
    input  logic [dhte_pkg::VAL_W-1:0]   i_value,
    input  logic [dhte_pkg::SLOT_W-1:0]  i_start_slot,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_status,
    output logic                         o_found,
    output logic [dhte_pkg::VAL_W-1:0]   o_value_out,
    output logic [dhte_pkg::KEY_W-1:0]   o_key_out,
    output logic [dhte_pkg::SLOT_W-1:0]  o_slot_out,
    output logic [dhte_pkg::COUNT_W-1:0] o_entry_count
);

    dhte_pkg::t_cmd cmd;
    dhte_pkg::t_sts sts;

    dhte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    dhte_dp #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_start_slot  (i_start_slot),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_value_out   (o_value_out),
        .o_key_out     (o_key_out),
        .o_slot_out    (o_slot_out),
        .o_entry_count (o_entry_count)
    );

endmodule

@@ rtl/core/dhte_ram.sv @@
module dhte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/core/dhte_ctrl.sv @@
module dhte_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dhte_pkg::t_sts i_sts,
    output dhte_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_PINIT = 4'd3;
    localparam logic [3:0] S_PRD   = 4'd4;
    localparam logic [3:0] S_PCHK  = 4'd5;
    localparam logic [3:0] S_ACT   = 4'd6;
    localparam logic [3:0] S_SRD   = 4'd7;
    localparam logic [3:0] S_SCHK  = 4'd8;
    localparam logic [3:0] S_FIN   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    // Sequence one request at a time
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (!i_sts.in_scan) begin
                        n_state = S_HASH;
                    end else if (i_sts.in_oob) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_SRD;
                    end
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                if (i_sts.hash_last) begin
                    n_state = S_PINIT;
                end
            end
            S_PINIT: begin
                o_cmd.pinit = 1'b1;
                n_state     = S_PRD;
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                o_cmd.pchk = 1'b1;
                n_state    = i_sts.chk_done ? S_ACT : S_PRD;
            end
            S_ACT: begin
                o_cmd.act = 1'b1;
                n_state   = S_FIN;
            end
            S_SRD: begin
                n_state = S_SCHK;
            end
            S_SCHK: begin
                o_cmd.schk = 1'b1;
                n_state    = i_sts.schk_done ? S_FIN : S_SRD;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/dhte_dp.sv @@
module dhte_dp #(
    parameter int TABLE_SLOTS = dhte_pkg::SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dhte_pkg::t_cmd               i_cmd,
    output dhte_pkg::t_sts               o_sts,
    input  logic [dhte_pkg::OP_W-1:0]    i_opcode,
    input  logic [dhte_pkg::KEY_W-1:0]   i_key,
    input  logic [dhte_pkg::VAL_W-1:0]   i_value,
    input  logic [dhte_pkg::SLOT_W-1:0]  i_start_slot,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_status,
    output logic                         o_found,
    output logic [dhte_pkg::VAL_W-1:0]   o_value_out,
    output logic [dhte_pkg::KEY_W-1:0]   o_key_out,
    output logic [dhte_pkg::SLOT_W-1:0]  o_slot_out,
    output logic [dhte_pkg::COUNT_W-1:0] o_entry_count
);

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int KW = dhte_pkg::KEY_W;
    localparam int VW = dhte_pkg::VAL_W;
    localparam int DW = 2 + KW + VW;
    localparam logic [IW:0]   MOD_A  = (IW+1)'(TABLE_SLOTS);
    localparam logic [IW-1:0] LAST   = IW'(TABLE_SLOTS - 1);
    localparam logic [IW:0]   N_LAST = (IW+1)'(TABLE_SLOTS - 1);
    localparam logic [CW-1:0] C_FULL = CW'(TABLE_SLOTS - 1);
    // Moduli and their reciprocals scaled by 2^31
    localparam logic [31:0]   M32_A  = 32'(TABLE_SLOTS);
    localparam logic [31:0]   M32_B  = 32'(TABLE_SLOTS - 1);
    localparam logic [31:0]   RCP_A  = 32'((64'd1 << 31) / TABLE_SLOTS);
    localparam logic [31:0]   RCP_B  = 32'((64'd1 << 31) / (TABLE_SLOTS - 1));

    // Request
    logic [dhte_pkg::OP_W-1:0] r_op;
    logic [KW-1:0]             r_key;
    logic [VW-1:0]             r_val;
    // Hash remainders
    logic [IW-1:0]             r_rem_a;
    logic [IW-1:0]             r_rem_b;
    logic [1:0]                r_hstep;
    logic [31:0]               r_q_a;
    logic [31:0]               r_q_b;
    logic [31:0]               r_d_a;
    logic [31:0]               r_d_b;
    // Probe state
    logic [IW-1:0]             r_idx;
    logic [IW-1:0]             r_jump;
    logic [IW:0]               r_n;
    logic [IW-1:0]             r_del;
    logic                      r_del_v;
    logic [IW-1:0]             r_tgt;
    logic                      r_tgt_v;
    logic                      r_hit;
    logic [VW-1:0]             r_old;
    // Scan and clearing pointers
    logic [IW-1:0]             r_scan;
    logic [IW-1:0]             r_clr;
    logic [CW-1:0]             r_count;
    // Pending result
    logic                      r_res_status;
    logic                      r_res_found;
    logic [VW-1:0]             r_res_vout;
    logic [KW-1:0]             r_res_kout;
    logic [IW-1:0]             r_res_sout;

    // Slot memory
    logic            we;
    logic [IW-1:0]   waddr;
    logic [DW-1:0]   wdata;
    logic [IW-1:0]   raddr;
    logic [DW-1:0]   rdata;
    logic [1:0]      rd_st;
    logic [KW-1:0]   rd_key;
    logic [VW-1:0]   rd_val;

    logic [KW-1:0]   key_x;
    logic [62:0]     prod_a;
    logic [62:0]     prod_b;
    logic [31:0]     rem_a;
    logic [31:0]     rem_b;
    logic [IW:0]     idx_sum;
    logic [IW-1:0]   idx_next;
    logic            slot_hit;
    logic            slot_empty;
    logic            slot_del;
    logic            probe_end;

    dhte_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_st  = rdata[DW-1 -: 2];
    assign rd_key = rdata[VW +: KW];
    assign rd_val = rdata[VW-1:0];
    assign raddr  = (r_op == dhte_pkg::OP_SCAN) ? r_scan : r_idx;

    // Quotient estimates by reciprocal multiplication, low by at most one
    assign key_x  = r_key ^ dhte_pkg::KEY_XOR;
    assign prod_a = {32'd0, key_x} * {31'd0, RCP_A};
    assign prod_b = {32'd0, r_key} * {31'd0, RCP_B};

    // Final correction of both remainders
    assign rem_a = (r_d_a >= M32_A) ? (r_d_a - M32_A) : r_d_a;
    assign rem_b = (r_d_b >= M32_B) ? (r_d_b - M32_B) : r_d_b;

    // Next probe position
    always_comb begin
        idx_sum = {1'b0, r_idx} + {1'b0, r_jump};
        if (idx_sum >= MOD_A) begin
            idx_sum = idx_sum - MOD_A;
        end
        idx_next = idx_sum[IW-1:0];
    end

    assign slot_hit   = (rd_st == dhte_pkg::ST_USED) && (rd_key == r_key);
    assign slot_empty = (rd_st == dhte_pkg::ST_EMPTY);
    assign slot_del   = (rd_st != dhte_pkg::ST_USED) && !slot_empty;
    assign probe_end  = slot_hit || slot_empty || (r_n == N_LAST);

    // Status to controller
    always_comb begin
        o_sts           = '0;
        o_sts.clr_done  = (r_clr == LAST);
        o_sts.in_scan   = (i_opcode == dhte_pkg::OP_SCAN);
        o_sts.in_oob    = (32'(i_start_slot) >= 32'(TABLE_SLOTS));
        o_sts.hash_last = (r_hstep == 2'd2);
        o_sts.chk_done  = probe_end;
        o_sts.schk_done = (rd_st == dhte_pkg::ST_USED) || (r_scan == LAST);
        o_sts.out_busy  = o_valid && !i_ready;
    end

    // Slot writes: clearing pass or request update
    always_comb begin
        we    = 1'b0;
        waddr = r_tgt;
        wdata = {dhte_pkg::ST_USED, r_key, r_val};
        if (i_cmd.clr) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = {dhte_pkg::ST_EMPTY, KW'(0), VW'(0)};
        end else if (i_cmd.act) begin
            case (r_op)
                dhte_pkg::OP_PUT: begin
                    we = r_tgt_v && (r_hit || (r_count < C_FULL));
                end
                dhte_pkg::OP_REM: begin
                    we    = r_hit;
                    wdata = {dhte_pkg::ST_DELETED, KW'(0), VW'(0)};
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    // Request, hash, probe, scan, result and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op         <= i_opcode;
            r_key        <= i_key;
            r_val        <= i_value;
            r_scan       <= IW'(i_start_slot);
            r_hstep      <= '0;
            r_res_status <= 1'b0;
            r_res_found  <= 1'b0;
            r_res_vout   <= '0;
            r_res_kout   <= '0;
            r_res_sout   <= '0;
        end
        // Quotient, then difference, then corrected remainder
        if (i_cmd.hash) begin
            r_hstep <= r_hstep + 2'd1;
            case (r_hstep)
                2'd0: begin
                    r_q_a <= prod_a[62:31];
                    r_q_b <= prod_b[62:31];
                end
                2'd1: begin
                    r_d_a <= {1'b0, key_x} - (r_q_a * M32_A);
                    r_d_b <= {1'b0, r_key} - (r_q_b * M32_B);
                end
                default: begin
                    r_rem_a <= rem_a[IW-1:0];
                    r_rem_b <= rem_b[IW-1:0];
                end
            endcase
        end
        if (i_cmd.pinit) begin
            r_idx   <= r_rem_a;
            r_jump  <= r_rem_b + IW'(1);
            r_n     <= '0;
            r_del_v <= 1'b0;
        end
        // Evaluate probed slot, remember first deleted slot
        if (i_cmd.pchk) begin
            r_old <= rd_val;
            if (slot_hit) begin
                r_hit   <= 1'b1;
                r_tgt   <= r_idx;
                r_tgt_v <= 1'b1;
            end else if (slot_empty) begin
                r_hit   <= 1'b0;
                r_tgt   <= r_del_v ? r_del : r_idx;
                r_tgt_v <= 1'b1;
            end else begin
                r_hit   <= 1'b0;
                r_tgt   <= (slot_del && !r_del_v) ? r_idx : r_del;
                r_tgt_v <= r_del_v || slot_del;
            end
            if (slot_del && !r_del_v) begin
                r_del   <= r_idx;
                r_del_v <= 1'b1;
            end
            r_idx <= idx_next;
            r_n   <= r_n + (IW+1)'(1);
        end
        // Form result of the request
        if (i_cmd.act) begin
            case (r_op)
                dhte_pkg::OP_GET: begin
                    r_res_found <= r_hit;
                    r_res_vout  <= r_hit ? r_old : '0;
                end
                dhte_pkg::OP_REM: begin
                    r_res_found <= r_hit;
                    r_res_vout  <= r_hit ? r_old : '0;
                end
                dhte_pkg::OP_PUT: begin
                    if (!r_tgt_v) begin
                        r_res_status <= 1'b1;
                    end else if (r_hit) begin
                        r_res_found <= 1'b1;
                        r_res_vout  <= (r_old == r_val) ? '0 : r_old;
                    end else if (r_count >= C_FULL) begin
                        r_res_status <= 1'b1;
                    end
                end
                default: begin
                    r_res_found <= 1'b0;
                end
            endcase
        end
        // Walk the scan pointer
        if (i_cmd.schk) begin
            if (rd_st == dhte_pkg::ST_USED) begin
                r_res_found <= 1'b1;
                r_res_kout  <= rd_key;
                r_res_sout  <= r_scan;
            end else begin
                r_scan <= r_scan + IW'(1);
            end
        end
        if (i_cmd.out_load) begin
            o_status      <= r_res_status;
            o_found       <= r_res_found;
            o_value_out   <= r_res_vout;
            o_key_out     <= r_res_kout;
            o_slot_out    <= dhte_pkg::SLOT_W'(r_res_sout);
            o_entry_count <= dhte_pkg::COUNT_W'(r_count);
        end
    end

    // Control registers: clearing pointer, occupancy, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cmd.act && r_op == dhte_pkg::OP_REM && r_hit) begin
                r_count <= r_count - CW'(1);
            end else if (i_cmd.act && r_op == dhte_pkg::OP_PUT && r_tgt_v && !r_hit
                         && r_count < C_FULL) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.out_load) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/core/dhte_checker.sv @@
module dhte_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_ready,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic                         o_status,
    input logic                         o_found,
    input logic [dhte_pkg::VAL_W-1:0]   o_value_out,
    input logic [dhte_pkg::KEY_W-1:0]   o_key_out,
    input logic [dhte_pkg::SLOT_W-1:0]  o_slot_out,
    input logic [dhte_pkg::COUNT_W-1:0] o_entry_count
);

    // Hold a stalled result transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_value_out) && $stable(o_found))
        else $error("result changed while stalled");

    // A refused put reports nothing found and a zero value
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_found && o_value_out == '0)
        else $error("refused put with data");

    // Without a hit no value, key or slot is reported
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_value_out == '0 && o_key_out == '0 && o_slot_out == '0)
        else $error("miss with data");

    // A taken request drops o_ready, so no second request is taken back to back
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken back to back");

endmodule

bind double_hash_table_engine dhte_checker u_dhte_checker (.*);

@@ bench/tb_double_hash_table_engine.sv @@
`timescale 1ns / 1ps

module tb_double_hash_table_engine;
    import dhte_pkg::*;

    localparam int SLOTS      = SLOTS_DEF;
    localparam int STALL_MAX  = 20000;
    localparam int DRAIN_WAIT = 64;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  val;
        logic [SLOT_W-1:0] start;
    } t_req;

    typedef struct {
        logic              status;
        logic              found;
        logic [VAL_W-1:0]  val;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] slot;
        logic [COUNT_W-1:0] count;
    } t_rsp;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [OP_W-1:0]     i_opcode;
    logic [KEY_W-1:0]    i_key;
    logic [VAL_W-1:0]    i_value;
    logic [SLOT_W-1:0]   i_start_slot;
    logic                o_valid;
    logic                i_ready;
    logic                o_status;
    logic                o_found;
    logic [VAL_W-1:0]    o_value_out;
    logic [KEY_W-1:0]    o_key_out;
    logic [SLOT_W-1:0]   o_slot_out;
    logic [COUNT_W-1:0]  o_entry_count;

    // Shadow table
    logic [1:0]       shadow_state [SLOTS];
    logic [KEY_W-1:0] shadow_key   [SLOTS];
    logic [VAL_W-1:0] shadow_val   [SLOTS];
    int unsigned      shadow_count;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    logic [KEY_W-1:0] key_pool[$];

    int planned_total;
    int reqs_sent;
    int rsps_seen;
    int mismatches;
    int stall_cycles;
    int refused_puts;
    int scan_hits;
    int key_hits;

    double_hash_table_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_opcode      (i_opcode),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_start_slot  (i_start_slot),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_value_out   (o_value_out),
        .o_key_out     (o_key_out),
        .o_slot_out    (o_slot_out),
        .o_entry_count (o_entry_count)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Walk the double-hash sequence; return matching or free slot, -1 if none
    function automatic int probe_slot(input logic [KEY_W-1:0] k, output bit hit);
        int unsigned idx;
        int unsigned jump;
        int          first_del;
        idx       = (k ^ KEY_XOR) % SLOTS;
        jump      = (k % (SLOTS - 1)) + 1;
        first_del = -1;
        hit       = 1'b0;
        for (int n = 0; n < SLOTS; n++) begin
            if (shadow_state[idx] == ST_USED) begin
                if (shadow_key[idx] == k) begin
                    hit = 1'b1;
                    return idx;
                end
            end else if (shadow_state[idx] == ST_EMPTY) begin
                return (first_del >= 0) ? first_del : idx;
            end else if (first_del < 0) begin
                first_del = idx;
            end
            idx = (idx + jump) % SLOTS;
        end
        return first_del;
    endfunction

    // Apply one request to the shadow table and form its result
    function automatic t_rsp apply_request(input t_req r);
        t_rsp res;
        bit   hit;
        int   idx;
        res = '{default: '0};
        if (r.op == OP_SCAN) begin
            for (int i = r.start; i < SLOTS; i++) begin
                if (shadow_state[i] == ST_USED) begin
                    res.found = 1'b1;
                    res.key   = shadow_key[i];
                    res.slot  = SLOT_W'(i);
                    break;
                end
            end
        end else begin
            idx = probe_slot(r.key, hit);
            if (r.op == OP_GET) begin
                if (hit) begin
                    res.found = 1'b1;
                    res.val   = shadow_val[idx];
                end
            end else if (r.op == OP_REM) begin
                if (hit) begin
                    res.found         = 1'b1;
                    res.val           = shadow_val[idx];
                    shadow_state[idx] = ST_DELETED;
                    shadow_val[idx]   = '0;
                    shadow_count--;
                end
            end else begin
                if (idx < 0) begin
                    res.status = 1'b1;
                end else if (hit) begin
                    res.found       = 1'b1;
                    res.val         = (shadow_val[idx] == r.val) ? '0 : shadow_val[idx];
                    shadow_val[idx] = r.val;
                end else if (shadow_count + 1 >= SLOTS) begin
                    res.status = 1'b1;
                end else begin
                    shadow_count++;
                    shadow_state[idx] = ST_USED;
                    shadow_key[idx]   = r.key;
                    shadow_val[idx]   = r.val;
                end
            end
        end
        res.count = shadow_count[COUNT_W-1:0];
        return res;
    endfunction

    task automatic queue_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v, input logic [SLOT_W-1:0] s);
        t_req r;
        r.op    = op;
        r.key   = k;
        r.val   = v;
        r.start = s;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [31:0] rand32();
        return $urandom();
    endfunction

    function automatic int sender_idle_pct();
        if (reqs_sent < planned_total / 3) return 20;
        if (reqs_sent < 2 * planned_total / 3) return 73;
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (reqs_sent < planned_total / 3) return 73;
        if (reqs_sent < 2 * planned_total / 3) return 20;
        return 0;
    endfunction

    // Driver: present requests, predict each accepted transaction
    always @(posedge i_clk) begin
        t_req nxt;
        bit   take;
        if (!i_rst_n) begin
            i_valid      <= 1'b0;
            i_opcode     <= OP_GET;
            i_key        <= '0;
            i_value      <= '0;
            i_start_slot <= '0;
        end else begin
            take = 1'b0;
            if (i_valid && o_ready) begin
                t_req cur;
                t_rsp res;
                cur.op    = i_opcode;
                cur.key   = i_key;
                cur.val   = i_value;
                cur.start = i_start_slot;
                res = apply_request(cur);
                if (res.status) refused_puts++;
                if (res.found && cur.op == OP_SCAN) scan_hits++;
                if (res.found && cur.op != OP_SCAN) key_hits++;
                expected_rsps.push_back(res);
                reqs_sent++;
                take = 1'b1;
            end else if (!i_valid) begin
                take = 1'b1;
            end
            if (take) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    nxt = pending_reqs.pop_front();
                    i_valid      <= 1'b1;
                    i_opcode     <= nxt.op;
                    i_key        <= nxt.key;
                    i_value      <= nxt.val;
                    i_start_slot <= nxt.start;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: throttle result ready and check each result transaction
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                rsps_seen++;
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result with nothing expected at %0t", $realtime);
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (o_status !== exp_rsp.status || o_found !== exp_rsp.found ||
                        o_value_out !== exp_rsp.val || o_key_out !== exp_rsp.key ||
                        o_slot_out !== exp_rsp.slot || o_entry_count !== exp_rsp.count) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: result %0d exp st=%0b fd=%0b val=%h key=%h ",
                                      "slot=%0d cnt=%0d got st=%0b fd=%0b val=%h key=%h ",
                                      "slot=%0d cnt=%0d"}, rsps_seen,
                                     exp_rsp.status, exp_rsp.found, exp_rsp.val, exp_rsp.key,
                                     exp_rsp.slot, exp_rsp.count, o_status, o_found,
                                     o_value_out, o_key_out, o_slot_out, o_entry_count);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("ERROR: no transaction for %0d cycles", STALL_MAX);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] fill_keys[$];
        int               pick;
        i_rst_n       = 1'b0;
        stall_cycles  = 0;
        reqs_sent     = 0;
        rsps_seen     = 0;
        mismatches    = 0;
        refused_puts  = 0;
        scan_hits     = 0;
        key_hits      = 0;
        shadow_count  = 0;
        for (int i = 0; i < SLOTS; i++) begin
            shadow_state[i] = ST_EMPTY;
            shadow_key[i]   = '0;
            shadow_val[i]   = '0;
        end

        // Directed: empty table, field extremes, overwrite, collisions, scan bounds
        queue_req(OP_GET,  31'd0,          32'd0,          11'd0);
        queue_req(OP_SCAN, 31'd0,          32'd0,          11'd0);
        queue_req(OP_PUT,  31'd0,          32'hFFFF_FFFF,  11'd0);
        queue_req(OP_PUT,  31'h7FFF_FFFF,  32'd0,          11'h7FF);
        queue_req(OP_PUT,  31'h7FFF_FFFF,  32'd0,          11'd0);
        queue_req(OP_PUT,  31'd0,          32'h1234_5678,  11'd0);
        queue_req(OP_GET,  31'd0,          32'd0,          11'd0);
        queue_req(OP_GET,  31'h7FFF_FFFF,  32'd0,          11'd0);
        queue_req(OP_REM,  31'd55,         32'd0,          11'd0);
        queue_req(OP_PUT,  31'd100,        32'hA5A5_A5A5,  11'd0);
        queue_req(OP_PUT,  31'd1131,       32'h5A5A_5A5A,  11'd0);
        queue_req(OP_REM,  31'd100,        32'd0,          11'd0);
        queue_req(OP_GET,  31'd1131,       32'd0,          11'd0);
        queue_req(OP_PUT,  31'd2162,       32'h0F0F_0F0F,  11'd0);
        queue_req(OP_REM,  31'd100,        32'd0,          11'd0);
        queue_req(OP_SCAN, 31'd0,          32'd0,          11'd0);
        queue_req(OP_SCAN, 31'd0,          32'd0,          11'd1030);
        queue_req(OP_SCAN, 31'd0,          32'd0,          11'd1031);
        queue_req(OP_SCAN, 31'd0,          32'd0,          11'h7FF);
        queue_req(OP_REM,  31'h7FFF_FFFF,  32'd0,          11'd0);
        queue_req(OP_GET,  31'h7FFF_FFFF,  32'd0,          11'd0);

        // Key pool: clusters sharing a first probe plus random keys
        for (int c = 0; c < 6; c++) begin
            k = KEY_W'($urandom_range(0, 32'h3FF_FFFF));
            for (int j = 0; j < 4; j++) key_pool.push_back(KEY_W'(k + j * SLOTS));
        end
        for (int j = 0; j < 24; j++) key_pool.push_back(KEY_W'(rand32()));

        // Random traffic over the pool, some noise keys
        for (int n = 0; n < 360; n++) begin
            pick = $urandom_range(99);
            k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(key_pool.size() - 1)]
                                          : KEY_W'(rand32());
            if (pick < 35)
                queue_req(OP_PUT, k, ($urandom_range(9) == 0) ? 32'd0 : rand32(),
                          SLOT_W'(rand32()));
            else if (pick < 65)
                queue_req(OP_GET, k, rand32(), SLOT_W'(rand32()));
            else if (pick < 85)
                queue_req(OP_REM, k, rand32(), SLOT_W'(rand32()));
            else
                queue_req(OP_SCAN, KEY_W'(rand32()), rand32(),
                          SLOT_W'(($urandom_range(9) == 0) ? rand32()
                                                           : $urandom_range(SLOTS - 1)));
        end

        // Load the table heavily, then work on the loaded table
        for (int n = 0; n < 150; n++) begin
            k = KEY_W'(rand32());
            fill_keys.push_back(k);
            queue_req(OP_PUT, k, rand32(), 11'd0);
        end
        for (int n = 0; n < 6; n++) begin
            queue_req(OP_GET, KEY_W'(rand32()), 32'd0, 11'd0);
            queue_req(OP_PUT, fill_keys[$urandom_range(fill_keys.size() - 1)], rand32(),
                      11'd0);
            queue_req(OP_SCAN, 31'd0, 32'd0, SLOT_W'($urandom_range(SLOTS - 1)));
        end
        for (int n = 0; n < 50; n++) begin
            pick = $urandom_range(99);
            k = fill_keys[$urandom_range(fill_keys.size() - 1)];
            if (pick < 50)      queue_req(OP_REM, k, 32'd0, 11'd0);
            else if (pick < 75) queue_req(OP_GET, k, 32'd0, 11'd0);
            else if (pick < 90) queue_req(OP_PUT, KEY_W'(rand32()), rand32(), 11'd0);
            else                queue_req(OP_SCAN, 31'd0, 32'd0,
                                          SLOT_W'($urandom_range(SLOTS - 1)));
        end
        planned_total = pending_reqs.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything sent and every result back
        while (pending_reqs.size() > 0 || i_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d requests, %0d results: %0d key hits, %0d scan hits, %0d refused puts",
                 reqs_sent, rsps_seen, key_hits, scan_hits, refused_puts);
        $display("Covered collision chains, deleted-slot reuse, a heavy load and scan bounds");
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("Mismatches: %0d", mismatches);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/dhte_pkg.sv
rtl/core/dhte_ram.sv
rtl/core/dhte_ctrl.sv
rtl/core/dhte_dp.sv
rtl/core/double_hash_table_engine.sv
rtl/core/dhte_checker.sv
bench/tb_double_hash_table_engine.sv
